// ===== design/ustmr_pkg.sv =====
// Shared constants, register offsets and types of the microsecond timer.
package ustmr_pkg;

    localparam int COUNT_W        = 64;
    localparam int WORD_W         = 32;
    localparam int OFFSET_W       = 12;
    localparam int FUNC_W         = 2;
    localparam int IRQ_W          = 4;
    localparam int NUM_ALARMS_DEF = 4;
    localparam int ALARM_SLOTS    = 4;

    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

    localparam logic [OFFSET_W-1:0] OFF_TIMEHW   = 12'h000;
    localparam logic [OFFSET_W-1:0] OFF_TIMELW   = 12'h004;
    localparam logic [OFFSET_W-1:0] OFF_TIMEHR   = 12'h008;
    localparam logic [OFFSET_W-1:0] OFF_TIMELR   = 12'h00C;
    localparam logic [OFFSET_W-1:0] OFF_ALARM0   = 12'h010;
    localparam logic [OFFSET_W-1:0] OFF_ARMED    = 12'h020;
    localparam logic [OFFSET_W-1:0] OFF_TIMERAWH = 12'h024;
    localparam logic [OFFSET_W-1:0] OFF_TIMERAWL = 12'h028;
    localparam logic [OFFSET_W-1:0] OFF_DBGPAUSE = 12'h02C;
    localparam logic [OFFSET_W-1:0] OFF_PAUSE    = 12'h030;
    localparam logic [OFFSET_W-1:0] OFF_INTR     = 12'h034;
    localparam logic [OFFSET_W-1:0] OFF_INTE     = 12'h038;
    localparam logic [OFFSET_W-1:0] OFF_INTF     = 12'h03C;
    localparam logic [OFFSET_W-1:0] OFF_INTS     = 12'h040;

    // Per-alarm strobes decoded from one bus beat.
    typedef struct packed {
        logic arm_wr;
        logic clr_armed;
        logic clr_raw;
    } t_lane_ctl;

endpackage

// ===== design/ustmr_alarm_lane.sv =====
// One compare alarm: stored 64-bit time, armed flag, raw interrupt and compare.
module ustmr_alarm_lane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  ustmr_pkg::t_lane_ctl              i_ctl,
    input  logic [ustmr_pkg::WORD_W-1:0]      i_write_data,
    input  logic [ustmr_pkg::WORD_W-1:0]      i_count_hi,
    input  logic [ustmr_pkg::COUNT_W-1:0]     i_count_n,
    output logic [ustmr_pkg::WORD_W-1:0]      o_alarm_low,
    output logic                              o_armed,
    output logic                              o_raw,
    output logic                              o_raw_n
);

    logic [ustmr_pkg::WORD_W-1:0] r_low;
    logic [ustmr_pkg::WORD_W-1:0] r_high;
    logic                         r_armed;
    logic                         r_raw;
    logic [ustmr_pkg::WORD_W-1:0] n_low;
    logic [ustmr_pkg::WORD_W-1:0] n_high;
    logic                         n_armed;
    logic                         n_raw;
    logic                         w_armed_wr;
    logic                         w_fire;

    // The bus update happens first, then the compare sees the updated time and count.
    always_comb begin
        n_low      = i_ctl.arm_wr ? i_write_data : r_low;
        n_high     = i_ctl.arm_wr ? i_count_hi : r_high;
        w_armed_wr = i_ctl.arm_wr | (r_armed & ~i_ctl.clr_armed);
        w_fire     = w_armed_wr && ({n_high, n_low} <= i_count_n);
        n_armed    = w_armed_wr & ~w_fire;
        n_raw      = (r_raw & ~i_ctl.clr_raw) | w_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low   <= '0;
            r_high  <= '0;
            r_armed <= 1'b0;
            r_raw   <= 1'b0;
        end else if (i_en) begin
            r_low   <= n_low;
            r_high  <= n_high;
            r_armed <= n_armed;
            r_raw   <= n_raw;
        end
    end

    assign o_alarm_low = r_low;
    assign o_armed     = r_armed;
    assign o_raw       = r_raw;
    assign o_raw_n     = n_raw;

`ifndef SYNTHESIS
    // An alarm left armed by a beat always lies beyond the count that beat produced.
    a_armed_in_future: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_en) && r_armed |-> ({r_high, r_low} > $past(i_count_n)))
        else $error("alarm left armed at or below the count");
`endif

endmodule

// ===== design/us_timer_with_four_alarms_unit.sv =====
// Top level of the 64-bit microsecond timer with compare alarms and bus register window.
//
// Every input beat is a microsecond tick, a register read or a register write, and every
// beat yields exactly one result beat carrying the read data (zero for ticks and writes),
// the four interrupt levels as they stand after the beat, and a flag for an access to an
// undefined or read-only offset. The block takes one beat per clock cycle when the output
// side keeps up; a beat waits in the input register, and its result is registered in the
// output register that drives the result ports. The cycle time is set by
// the 64-bit count increment feeding the per-alarm 64-bit compares, which run side by side.
// Reading TIMEHW latches the count so that a later TIMELW read returns the matching low
// word. Writing an alarm stores its low word, takes the current high word of the count and
// arms it; an armed alarm whose time is at or below the count fires its own raw interrupt
// bit and disarms. ARMED and INTR clear on a write of one. Only the lowest four alarms are
// reachable on the bus and drive the interrupt lines; the debug pause field is storage only.
module us_timer_with_four_alarms_unit #(
    parameter int NUM_ALARMS = ustmr_pkg::NUM_ALARMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ustmr_pkg::FUNC_W-1:0]      i_func,
    input  logic [ustmr_pkg::OFFSET_W-1:0]    i_offset,
    input  logic [ustmr_pkg::WORD_W-1:0]      i_write_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ustmr_pkg::WORD_W-1:0]      o_read_data,
    output logic [ustmr_pkg::IRQ_W-1:0]       o_irq_lines,
    output logic                              o_bad_access
);

    localparam int StatusW = (NUM_ALARMS > ustmr_pkg::IRQ_W) ? NUM_ALARMS : ustmr_pkg::IRQ_W;
    localparam int Hi      = ustmr_pkg::COUNT_W - 1;
    localparam int Lo      = ustmr_pkg::WORD_W;

    // Input register.
    logic                           r_in_valid;
    logic [ustmr_pkg::FUNC_W-1:0]   r_in_func;
    logic [ustmr_pkg::OFFSET_W-1:0] r_in_offset;
    logic [ustmr_pkg::WORD_W-1:0]   r_in_wdata;

    // Timer state.
    logic [ustmr_pkg::COUNT_W-1:0]  r_count;
    logic [ustmr_pkg::COUNT_W-1:0]  n_count;
    logic [ustmr_pkg::WORD_W-1:0]   r_latched_lo;
    logic [1:0]                     r_dbg_pause;
    logic                           r_pause;
    logic [NUM_ALARMS-1:0]          r_inte;
    logic [NUM_ALARMS-1:0]          r_intf;
    logic [NUM_ALARMS-1:0]          n_inte;
    logic [NUM_ALARMS-1:0]          n_intf;

    // Result register.
    logic                           r_out_valid;
    logic [ustmr_pkg::WORD_W-1:0]   r_read_data;
    logic [ustmr_pkg::IRQ_W-1:0]    r_irq;
    logic                           r_bad;

    // Beat processing.
    logic                           w_in_accept;
    logic                           w_proc;
    logic                           w_is_read;
    logic                           w_is_write;
    logic [ustmr_pkg::OFFSET_W-1:0] w_alarm_idx;
    logic                           w_alarm_hit;
    logic [ustmr_pkg::WORD_W-1:0]   w_rd_data;
    logic [ustmr_pkg::WORD_W-1:0]   w_alarm_rd;
    logic                           w_bad;
    logic                           w_latch;
    logic                           w_wr_timelw;
    logic                           w_wr_armed;
    logic                           w_wr_dbg;
    logic                           w_wr_pause;
    logic                           w_wr_intr;
    logic                           w_wr_inte;
    logic                           w_wr_intf;

    // Alarm lanes.
    ustmr_pkg::t_lane_ctl           w_ctl [NUM_ALARMS];
    logic [ustmr_pkg::WORD_W-1:0]   w_alarm_low [NUM_ALARMS];
    logic [NUM_ALARMS-1:0]          w_armed;
    logic [NUM_ALARMS-1:0]          w_raw;
    logic [NUM_ALARMS-1:0]          w_raw_n;
    logic [NUM_ALARMS-1:0]          w_status;
    logic [NUM_ALARMS-1:0]          w_status_n;
    logic [StatusW-1:0]             w_status_wide;

    // Handshake: the input register moves on whenever the result register is free or drains.
    assign w_proc      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_proc;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_func   <= i_func;
            r_in_offset <= i_offset;
            r_in_wdata  <= i_write_data;
        end
    end

    assign w_is_read  = (r_in_func == ustmr_pkg::FUNC_READ);
    assign w_is_write = (r_in_func == ustmr_pkg::FUNC_WRITE);

    // Alarm registers sit word-aligned in a row of slots; slots past the last alarm are holes.
    assign w_alarm_idx = (r_in_offset - ustmr_pkg::OFF_ALARM0) >> 2;
    assign w_alarm_hit = (r_in_offset >= ustmr_pkg::OFF_ALARM0)
                      && (r_in_offset < ustmr_pkg::OFFSET_W'(ustmr_pkg::OFF_ALARM0
                                                            + 4 * ustmr_pkg::ALARM_SLOTS))
                      && (r_in_offset[1:0] == 2'b00)
                      && (32'(w_alarm_idx) < NUM_ALARMS);

    always_comb begin
        w_alarm_rd = '0;
        for (int i = 0; i < NUM_ALARMS; i++) begin
            if (w_alarm_hit && (32'(w_alarm_idx) == i)) begin
                w_alarm_rd = w_alarm_rd | w_alarm_low[i];
            end
        end
    end

    assign w_status = (w_raw | r_intf) & r_inte;

    // Register decode. Reads and writes see the state as it stood before this beat.
    always_comb begin
        w_rd_data   = '0;
        w_bad       = 1'b0;
        w_latch     = 1'b0;
        w_wr_timelw = 1'b0;
        w_wr_armed  = 1'b0;
        w_wr_dbg    = 1'b0;
        w_wr_pause  = 1'b0;
        w_wr_intr   = 1'b0;
        w_wr_inte   = 1'b0;
        w_wr_intf   = 1'b0;
        if (w_is_read) begin
            if (w_alarm_hit) begin
                w_rd_data = w_alarm_rd;
            end else begin
                unique case (r_in_offset) inside
                    ustmr_pkg::OFF_TIMEHW: begin
                        w_rd_data = r_count[Hi:Lo];
                        w_latch   = 1'b1;
                    end
                    ustmr_pkg::OFF_TIMELW:   w_rd_data = r_latched_lo;
                    ustmr_pkg::OFF_TIMEHR,
                    ustmr_pkg::OFF_TIMERAWH: w_rd_data = r_count[Hi:Lo];
                    ustmr_pkg::OFF_TIMELR,
                    ustmr_pkg::OFF_TIMERAWL: w_rd_data = r_count[Lo-1:0];
                    ustmr_pkg::OFF_ARMED:    w_rd_data = ustmr_pkg::WORD_W'(w_armed);
                    ustmr_pkg::OFF_DBGPAUSE: w_rd_data = ustmr_pkg::WORD_W'(r_dbg_pause);
                    ustmr_pkg::OFF_PAUSE:    w_rd_data = ustmr_pkg::WORD_W'(r_pause);
                    ustmr_pkg::OFF_INTR:     w_rd_data = ustmr_pkg::WORD_W'(w_raw);
                    ustmr_pkg::OFF_INTE:     w_rd_data = ustmr_pkg::WORD_W'(r_inte);
                    ustmr_pkg::OFF_INTF:     w_rd_data = ustmr_pkg::WORD_W'(r_intf);
                    ustmr_pkg::OFF_INTS:     w_rd_data = ustmr_pkg::WORD_W'(w_status);
                    default:                 w_bad     = 1'b1;
                endcase
            end
        end else if (w_is_write && !w_alarm_hit) begin
            // Read-only registers fall to the default arm along with the holes.
            unique case (r_in_offset) inside
                ustmr_pkg::OFF_TIMELW:   w_wr_timelw = 1'b1;
                ustmr_pkg::OFF_ARMED:    w_wr_armed  = 1'b1;
                ustmr_pkg::OFF_DBGPAUSE: w_wr_dbg    = 1'b1;
                ustmr_pkg::OFF_PAUSE:    w_wr_pause  = 1'b1;
                ustmr_pkg::OFF_INTR:     w_wr_intr   = 1'b1;
                ustmr_pkg::OFF_INTE:     w_wr_inte   = 1'b1;
                ustmr_pkg::OFF_INTF:     w_wr_intf   = 1'b1;
                default:                 w_bad       = 1'b1;
            endcase
        end
    end

    // Next count: a tick advances it unless paused, a TIMELW write loads it with a zero high word.
    always_comb begin
        n_count = r_count;
        if ((r_in_func == ustmr_pkg::FUNC_TICK) && !r_pause) begin
            n_count = r_count + ustmr_pkg::COUNT_W'(1);
        end
        if (w_wr_timelw) begin
            n_count = ustmr_pkg::COUNT_W'(r_in_wdata);
        end
    end

    assign n_inte = w_wr_inte ? r_in_wdata[NUM_ALARMS-1:0] : r_inte;
    assign n_intf = w_wr_intf ? r_in_wdata[NUM_ALARMS-1:0] : r_intf;

    always_comb begin
        for (int i = 0; i < NUM_ALARMS; i++) begin
            w_ctl[i].arm_wr    = w_is_write && w_alarm_hit && (32'(w_alarm_idx) == i);
            w_ctl[i].clr_armed = w_wr_armed && r_in_wdata[i];
            w_ctl[i].clr_raw   = w_wr_intr && r_in_wdata[i];
        end
    end

    for (genvar g = 0; g < NUM_ALARMS; g++) begin : g_lane
        ustmr_alarm_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (w_proc),
            .i_ctl        (w_ctl[g]),
            .i_write_data (r_in_wdata),
            .i_count_hi   (r_count[Hi:Lo]),
            .i_count_n    (n_count),
            .o_alarm_low  (w_alarm_low[g]),
            .o_armed      (w_armed[g]),
            .o_raw        (w_raw[g]),
            .o_raw_n      (w_raw_n[g])
        );
    end

    // Interrupt levels after the beat; only the lowest alarms reach the output lines.
    assign w_status_n    = (w_raw_n | n_intf) & n_inte;
    assign w_status_wide = StatusW'(w_status_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_latched_lo <= '0;
            r_dbg_pause  <= '0;
            r_pause      <= 1'b0;
            r_inte       <= '0;
            r_intf       <= '0;
        end else if (w_proc) begin
            r_count <= n_count;
            r_inte  <= n_inte;
            r_intf  <= n_intf;
            if (w_latch) begin
                r_latched_lo <= r_count[Lo-1:0];
            end
            if (w_wr_dbg) begin
                r_dbg_pause <= r_in_wdata[1:0];
            end
            if (w_wr_pause) begin
                r_pause <= r_in_wdata[0];
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_read_data <= w_rd_data;
            r_irq       <= w_status_wide[ustmr_pkg::IRQ_W-1:0];
            r_bad       <= w_bad;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_data  = r_read_data;
    assign o_irq_lines  = r_irq;
    assign o_bad_access = r_bad;

`ifndef SYNTHESIS
    // Every beat taken from the input register shows up as a result on the next edge.
    a_proc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc |=> r_out_valid)
        else $error("processed beat produced no result");

    // A tick while paused leaves the count alone.
    a_pause_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && (r_in_func == ustmr_pkg::FUNC_TICK) && r_pause |=> $stable(r_count))
        else $error("count moved while paused");

    // Loading the count through TIMELW clears the high word.
    a_load_clears_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && w_wr_timelw |=> (r_count[Hi:Lo] == '0))
        else $error("count load left a nonzero high word");

    // The input side only stalls when a beat is waiting in the input register.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with an empty input register");
`endif

endmodule
